### design/tgr_pkg.sv
// ---------------------------------------------------------------------------
// tgr_pkg
// shared types and constants of the text glyph renderer
// ---------------------------------------------------------------------------
package tgr_pkg;

  localparam int FONT_AW  = 12;
  localparam int FONT_DW  = 16;
  localparam int ROW_W    = 4;
  localparam int COORD_W  = 12;
  localparam int CODE_W   = 8;
  localparam int MASK_W   = 8;
  localparam int REQ_W    = 2;
  localparam int START_W  = 11;

  localparam logic [REQ_W-1:0]  REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0]  REQ_START = 2'd1;
  localparam logic [REQ_W-1:0]  REQ_CHAR  = 2'd2;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic signed [COORD_W:0] COORD_MAX = 13'sd2047;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             last;
  } row_req_t;

endpackage

### design/tgr_font_mem.sv
// ---------------------------------------------------------------------------
// tgr_font_mem
// glyph row store, one write and one registered read port
// ---------------------------------------------------------------------------
module tgr_font_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [tgr_pkg::FONT_AW-1:0] wr_addr,
  input  logic [tgr_pkg::FONT_DW-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [tgr_pkg::FONT_AW-1:0] rd_addr,
  output logic [tgr_pkg::FONT_DW-1:0] rd_data
);
  import tgr_pkg::*;

  logic [FONT_DW-1:0] mem [2**FONT_AW];
  logic [FONT_DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/tgr_row_unit.sv
// ---------------------------------------------------------------------------
// tgr_row_unit
// clips one glyph row against the screen and registers the row write
// ---------------------------------------------------------------------------
module tgr_row_unit #(
  parameter int GLYPH_WIDTH   = 8,
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tgr_pkg::row_req_t                  req,
  input  logic [tgr_pkg::FONT_DW-1:0]        line,
  input  logic signed [tgr_pkg::COORD_W-1:0] cur_x,
  input  logic signed [tgr_pkg::COORD_W-1:0] cur_y,
  output logic                               out_valid,
  output logic signed [tgr_pkg::COORD_W-1:0] out_col_x,
  output logic signed [tgr_pkg::COORD_W-1:0] out_row_y,
  output logic [tgr_pkg::MASK_W-1:0]         out_row_mask,
  output logic                               out_last_row
);
  import tgr_pkg::*;

  logic                      valid_r;
  logic signed [COORD_W-1:0] col_x_r, col_x_nxt;
  logic signed [COORD_W-1:0] row_y_r, row_y_nxt;
  logic [MASK_W-1:0]         mask_r, mask_nxt;
  logic                      last_r;

  logic signed [COORD_W:0]   y_s;
  logic signed [COORD_W:0]   x_s;
  logic                      y_ok;

  always_comb begin
    y_s  = $signed({cur_y[COORD_W-1], cur_y}) +
           $signed({{(COORD_W+1-ROW_W){1'b0}}, req.row});
    y_ok = (y_s >= 0) && (y_s < $signed((COORD_W+1)'(SCREEN_HEIGHT)));
    row_y_nxt = (y_s > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : y_s[COORD_W-1:0];
    col_x_nxt = cur_x;
    mask_nxt  = '0;
    x_s       = '0;
    for (int j = 0; j < MASK_W; j++) begin
      x_s = $signed({cur_x[COORD_W-1], cur_x}) + $signed((COORD_W+1)'(j));
      if ((j < GLYPH_WIDTH) && line[FONT_DW-1-j] && y_ok && (x_s >= 0) &&
          (x_s < $signed((COORD_W+1)'(SCREEN_WIDTH)))) begin
        mask_nxt[MASK_W-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      col_x_r <= col_x_nxt;
      row_y_r <= row_y_nxt;
      mask_r  <= mask_nxt;
      last_r  <= req.last;
    end
  end

  assign out_valid    = valid_r;
  assign out_col_x    = col_x_r;
  assign out_row_y    = row_y_r;
  assign out_row_mask = mask_r;
  assign out_last_row = last_r;

endmodule

### design/text_glyph_renderer_core.sv
// ---------------------------------------------------------------------------
// text_glyph_renderer_core
// draws text from a bitmap font as a stream of clipped glyph row writes
// ---------------------------------------------------------------------------
// A load, start or newline request is taken while idle and busy stays low.
// Any other character reads one font row per cycle from the single font
// store port; busy is high through the read state and the wait state after
// it, and the next request is taken once busy is low again. Row writes
// appear on out_valid, one per cycle and back to back, GLYPH_HEIGHT of them,
// the final one flagged by out_last_row; they cannot be held off, so the
// receiver must take every cycle in which out_valid is high.
module text_glyph_renderer_core #(
  parameter int GLYPH_HEIGHT  = 16,
  parameter int GLYPH_WIDTH   = 8,
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tgr_pkg::REQ_W-1:0]          in_req_type,
  input  logic [tgr_pkg::FONT_AW-1:0]        in_font_addr,
  input  logic [tgr_pkg::FONT_DW-1:0]        in_font_bits,
  input  logic signed [tgr_pkg::START_W-1:0] in_start_x,
  input  logic signed [tgr_pkg::START_W-1:0] in_start_y,
  input  logic [tgr_pkg::CODE_W-1:0]         in_char_code,
  output logic                               out_valid,
  output logic signed [tgr_pkg::COORD_W-1:0] out_col_x,
  output logic signed [tgr_pkg::COORD_W-1:0] out_row_y,
  output logic [tgr_pkg::MASK_W-1:0]         out_row_mask,
  output logic                               out_last_row
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);

  state_t                    state_r, state_nxt;
  logic [CODE_W-1:0]         code_r, code_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  row_req_t                  p1_r, p1_nxt;
  logic signed [COORD_W-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [COORD_W-1:0] cursor_y_r, cursor_y_nxt;
  logic signed [COORD_W-1:0] origin_x_r, origin_x_nxt;

  logic                      accept;
  logic                      mem_we;
  logic                      mem_re;
  logic [FONT_DW-1:0]        mem_rdata;
  logic signed [COORD_W:0]   x_adv;
  logic signed [COORD_W:0]   y_adv;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign mem_we = accept && (in_req_type == REQ_LOAD);
  assign mem_re = (state_r == S_RUN);

  always_comb begin
    x_adv = $signed({cursor_x_r[COORD_W-1], cursor_x_r}) +
            $signed((COORD_W+1)'(GLYPH_WIDTH));
    y_adv = $signed({cursor_y_r[COORD_W-1], cursor_y_r}) +
            $signed((COORD_W+1)'(GLYPH_HEIGHT));
  end

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    row_nxt      = row_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    origin_x_nxt = origin_x_r;
    p1_nxt.valid = 1'b0;
    p1_nxt.row   = row_r;
    p1_nxt.last  = (row_r == LAST_ROW);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_START: begin
              origin_x_nxt = {in_start_x[START_W-1], in_start_x};
              cursor_x_nxt = {in_start_x[START_W-1], in_start_x};
              cursor_y_nxt = {in_start_y[START_W-1], in_start_y};
            end
            REQ_CHAR: begin
              if (in_char_code == NEWLINE_CODE) begin
                cursor_x_nxt = origin_x_r;
                cursor_y_nxt = (y_adv > COORD_MAX) ? COORD_MAX[COORD_W-1:0]
                                                   : y_adv[COORD_W-1:0];
              end else begin
                code_nxt  = in_char_code;
                row_nxt   = '0;
                state_nxt = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        p1_nxt.valid = 1'b1;
        row_nxt      = row_r + 1'b1;
        if (row_r == LAST_ROW) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // cursor moves on once the last row has been clipped
    if (p1_r.valid && p1_r.last) begin
      cursor_x_nxt = (x_adv > COORD_MAX) ? COORD_MAX[COORD_W-1:0]
                                         : x_adv[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      p1_r       <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      origin_x_r <= '0;
    end else begin
      state_r    <= state_nxt;
      p1_r       <= p1_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      origin_x_r <= origin_x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    row_r  <= row_nxt;
  end

  tgr_font_mem u_font_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (in_font_addr),
    .wr_data (in_font_bits),
    .rd_en   (mem_re),
    .rd_addr ({code_r, row_r}),
    .rd_data (mem_rdata)
  );

  tgr_row_unit #(
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_row_unit (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (p1_r),
    .line         (mem_rdata),
    .cur_x        (cursor_x_r),
    .cur_y        (cursor_y_r),
    .out_valid    (out_valid),
    .out_col_x    (out_col_x),
    .out_row_y    (out_row_y),
    .out_row_mask (out_row_mask),
    .out_last_row (out_last_row)
  );

endmodule

### design/tgr_checker.sv
// ---------------------------------------------------------------------------
// tgr_checker
// port level checks of the glyph row stream, bound to the core
// ---------------------------------------------------------------------------
module tgr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [tgr_pkg::REQ_W-1:0]          in_req_type,
  input logic [tgr_pkg::CODE_W-1:0]         in_char_code,
  input logic                               out_valid,
  input logic signed [tgr_pkg::COORD_W-1:0] out_col_x,
  input logic                               out_last_row
);
  import tgr_pkg::*;

  // rows of one character come back to back
  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> out_valid)
    else $error("glyph row stream broken before last row");

  // nothing directly follows the last row
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |=> !out_valid)
    else $error("row write right after last row");

  // a character's rows all share one column
  a_col_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> $stable(out_col_x))
    else $error("column changed within a character");

  // a drawn character holds off new requests
  a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_CHAR) && (in_char_code != NEWLINE_CODE)
    |=> busy)
    else $error("not busy after character request");

  // only the last row may be seen with busy low
  a_busy_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |-> busy)
    else $error("row write while idle");

endmodule

bind text_glyph_renderer_core tgr_checker u_tgr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_req_type  (in_req_type),
  .in_char_code (in_char_code),
  .out_valid    (out_valid),
  .out_col_x    (out_col_x),
  .out_last_row (out_last_row)
);
